### sv/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants for the port mapping table
// Command and status codes, table entry layout, sequencer states and the
// request/result bundles passed between the top level and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pmt_pkg;

  localparam int TableDepthDefault = 128;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef struct packed {
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  interface_id;
  } entry_t;

  typedef struct packed {
    logic [1:0] command;
    entry_t     fields;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] mapped_port;
  } result_t;

endpackage

`default_nettype wire

### sv/pmt_engine.sv
// ----------------------------------------------------------------------------
// pmt_engine: table storage and command sequencer
// Holds the entries in a single-port-write, registered-read memory and walks
// them one at a time with one shared compare unit; remove then shifts
// the later entries down one place.
// ----------------------------------------------------------------------------
`default_nettype none

module pmt_engine #(
  parameter int TABLE_DEPTH = pmt_pkg::TableDepthDefault
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire pmt_pkg::request_t req_in,
  output logic                  done,
  output pmt_pkg::result_t      result
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);
  localparam int XW   = CntW + 1;

  pmt_pkg::entry_t mem [TABLE_DEPTH];
  pmt_pkg::entry_t rd_data;

  pmt_pkg::state_t   state, state_next;
  logic [IdxW-1:0]   idx, idx_next;
  logic [CntW-1:0]   count, count_next;
  pmt_pkg::request_t req;

  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [IdxW-1:0]   raddr;
  pmt_pkg::entry_t   wdata;

  logic [XW-1:0]     idx_p1, idx_p2, cnt_x;
  logic              hit;

  assign idx_p1 = XW'(idx) + XW'(1);
  assign idx_p2 = XW'(idx) + XW'(2);
  assign cnt_x  = XW'(count);

  always_comb begin
    if (pmt_pkg::cmd_t'(req.command) == pmt_pkg::CMD_REMOVE) begin
      hit = (rd_data.source_port == req.fields.source_port) &&
            (rd_data.dest_port == req.fields.dest_port);
    end else begin
      hit = (rd_data.source_port == req.fields.source_port) &&
            (rd_data.interface_id == req.fields.interface_id);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (start) begin
      req <= req_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmt_pkg::S_IDLE;
      idx   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next         = state;
    idx_next           = idx;
    count_next         = count;
    we                 = 1'b0;
    waddr              = idx;
    wdata              = rd_data;
    raddr              = idx;
    done               = 1'b0;
    result.status      = pmt_pkg::ST_NONE;
    result.mapped_port = '0;

    unique case (state)
      pmt_pkg::S_IDLE: begin
        if (start) begin
          priority case (pmt_pkg::cmd_t'(req_in.command))
            pmt_pkg::CMD_ADD: begin
              done = 1'b1;
              if (count == CntW'(TABLE_DEPTH)) begin
                result.status = pmt_pkg::ST_FULL;
              end else begin
                we            = 1'b1;
                waddr         = count[IdxW-1:0];
                wdata         = req_in.fields;
                count_next    = count + CntW'(1);
                result.status = pmt_pkg::ST_OK;
              end
            end
            pmt_pkg::CMD_REMOVE, pmt_pkg::CMD_LOOKUP: begin
              if (count == '0) begin
                done = 1'b1;
              end else begin
                idx_next   = '0;
                state_next = pmt_pkg::S_READ;
              end
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      pmt_pkg::S_READ: begin
        state_next = pmt_pkg::S_CMP;
      end
      pmt_pkg::S_CMP: begin
        if (hit) begin
          if (pmt_pkg::cmd_t'(req.command) == pmt_pkg::CMD_LOOKUP) begin
            done               = 1'b1;
            result.status      = pmt_pkg::ST_OK;
            result.mapped_port = rd_data.dest_port;
            state_next         = pmt_pkg::S_IDLE;
          end else if (idx_p1 < cnt_x) begin
            state_next = pmt_pkg::S_SHIFT_RD;
          end else begin
            done          = 1'b1;
            result.status = pmt_pkg::ST_OK;
            count_next    = count - CntW'(1);
            state_next    = pmt_pkg::S_IDLE;
          end
        end else if (idx_p1 >= cnt_x) begin
          done       = 1'b1;
          state_next = pmt_pkg::S_IDLE;
        end else begin
          idx_next   = idx_p1[IdxW-1:0];
          state_next = pmt_pkg::S_READ;
        end
      end
      pmt_pkg::S_SHIFT_RD: begin
        raddr      = idx_p1[IdxW-1:0];
        state_next = pmt_pkg::S_SHIFT_WR;
      end
      pmt_pkg::S_SHIFT_WR: begin
        we    = 1'b1;
        waddr = idx;
        wdata = rd_data;
        if (idx_p2 < cnt_x) begin
          idx_next   = idx_p1[IdxW-1:0];
          state_next = pmt_pkg::S_SHIFT_RD;
        end else begin
          done          = 1'b1;
          result.status = pmt_pkg::ST_OK;
          count_next    = count - CntW'(1);
          state_next    = pmt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pmt_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(count) <= XW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == pmt_pkg::S_IDLE))
    else $error("request started while engine busy");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == pmt_pkg::S_SHIFT_WR) |-> (idx_p1 < cnt_x))
    else $error("compaction write past last entry");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    (done && (state == pmt_pkg::S_IDLE)) |-> start)
    else $error("result without request");
`endif

endmodule

`default_nettype wire

### sv/port_map_table.sv
// ----------------------------------------------------------------------------
// port_map_table: ordered port mapping table
// Add, remove and lookup commands on an ordered table of
// (source port, destination port, interface) entries.
//
// Request channel: req_valid/req_stall with command, source_port, dest_port
// and interface_id. Result channel: res_valid/res_stall with status and
// mapped_port; exactly one result per request, in order.
// One request is handled at a time: req_stall stays high from the accepted
// request until its result has been taken.
// Add, and remove/lookup on an empty table, give the result in the cycle
// after the request. A lookup reads and compares the entries in order
// until one hits or all entries are scanned. A remove that hits then moves
// each later entry down one place, reading it and writing it back one
// place lower. Entries are compared or moved one at a time through the
// single memory read port.
// Reset empties the table; entry contents are not cleared.
// A stalled result holds in the output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module port_map_table #(
  parameter int TABLE_DEPTH = pmt_pkg::TableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  command,
  input  wire logic [15:0] source_port,
  input  wire logic [15:0] dest_port,
  input  wire logic [7:0]  interface_id,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       status,
  output logic [15:0]      mapped_port
);

  logic              busy;
  logic              start;
  logic              done;
  pmt_pkg::request_t req_in;
  pmt_pkg::result_t  eng_result;
  pmt_pkg::result_t  res_q;

  assign req_stall = busy;
  assign start     = req_valid && !busy;

  assign req_in.command             = command;
  assign req_in.fields.source_port  = source_port;
  assign req_in.fields.dest_port    = dest_port;
  assign req_in.fields.interface_id = interface_id;

  pmt_engine #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_engine (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req_in (req_in),
    .done   (done),
    .result (eng_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (res_valid && !res_stall) begin
        busy <= 1'b0;
      end
      if (done) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_q <= eng_result;
    end
  end

  assign status      = res_q.status;
  assign mapped_port = res_q.mapped_port;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done |-> !res_valid)
    else $error("result overwritten before taken");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> busy)
    else $error("result pending while not busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy)
    else $error("busy not set after request");
`endif

endmodule

`default_nettype wire

### sim/port_map_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// port_map_table_tb: self-checking bench for the ordered port mapping table
// Drives add, remove, lookup and reserved requests, first a directed set,
// then random phases that fill, saturate and drain the table. A scoreboard
// keeps its own ordered copy of the table, predicts status and mapped port
// for each accepted request and checks every result in order. Both
// handshakes idle in random bursts.
// ----------------------------------------------------------------------------

module port_map_table_tb;

  localparam int TableDepth = pmt_pkg::TableDepthDefault;
  localparam logic [1:0] CmdReserved = 2'd3;
  localparam int CycleLimit = 1_500_000;

  class map_table_tracker;
    int depth;
    int errors;
    logic [15:0] src_q[$];
    logic [15:0] dst_q[$];
    logic [7:0]  ifc_q[$];
    pmt_pkg::result_t expected_q[$];

    function new(int d);
      depth = d;
      errors = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int random_index();
      if (src_q.size() == 0) return -1;
      return $urandom_range(src_q.size() - 1);
    endfunction

    function void note_request(logic [1:0] cmd, logic [15:0] sp, logic [15:0] dp,
                               logic [7:0] ifc);
      pmt_pkg::result_t r;
      int hit;
      r.status = pmt_pkg::ST_NONE;
      r.mapped_port = '0;
      hit = -1;
      case (cmd)
        pmt_pkg::CMD_ADD: begin
          if (src_q.size() >= depth) begin
            r.status = pmt_pkg::ST_FULL;
          end else begin
            src_q.push_back(sp);
            dst_q.push_back(dp);
            ifc_q.push_back(ifc);
            r.status = pmt_pkg::ST_OK;
          end
        end
        pmt_pkg::CMD_REMOVE: begin
          foreach (src_q[i])
            if (hit < 0 && src_q[i] == sp && dst_q[i] == dp) hit = i;
          if (hit >= 0) begin
            src_q.delete(hit);
            dst_q.delete(hit);
            ifc_q.delete(hit);
            r.status = pmt_pkg::ST_OK;
          end
        end
        pmt_pkg::CMD_LOOKUP: begin
          foreach (src_q[i])
            if (hit < 0 && src_q[i] == sp && ifc_q[i] == ifc) hit = i;
          if (hit >= 0) begin
            r.status = pmt_pkg::ST_OK;
            r.mapped_port = dst_q[hit];
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] mp);
      pmt_pkg::result_t r;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: status %0d mapped_port %0d", st, mp);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d, actual %0d", r.status, st);
        errors++;
      end
      if (mp !== r.mapped_port) begin
        $error("mapped_port: expected %0d, actual %0d", r.mapped_port, mp);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  command = '0;
  logic [15:0] source_port = '0;
  logic [15:0] dest_port = '0;
  logic [7:0]  interface_id = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] mapped_port;

  map_table_tracker tracker;
  bit sender_idle = 1'b1;
  bit receiver_idle = 1'b1;
  int burst_left = 0;
  bit stall_burst = 1'b0;
  int cycle_count;

  port_map_table #(.TABLE_DEPTH(TableDepth)) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .command(command),
    .source_port(source_port),
    .dest_port(dest_port),
    .interface_id(interface_id),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .status(status),
    .mapped_port(mapped_port)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // result side: check, then pick the next stall level
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_result(status, mapped_port);
    if (burst_left == 0) begin
      burst_left = $urandom_range(18, 1);
      stall_burst = receiver_idle && ($urandom_range(2) == 0);
    end
    burst_left--;
    res_stall <= stall_burst;
  end

  function automatic logic [15:0] pick_port();
    logic [15:0] pool[6] = '{16'h0000, 16'h0001, 16'h0050, 16'h1F90, 16'h8000, 16'hFFFF};
    if ($urandom_range(4) == 0) return 16'($urandom);
    return pool[$urandom_range(5)];
  endfunction

  function automatic logic [7:0] pick_iface();
    logic [7:0] pool[4] = '{8'h00, 8'h01, 8'h80, 8'hFF};
    if ($urandom_range(4) == 0) return 8'($urandom);
    return pool[$urandom_range(3)];
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [15:0] sp,
                              input logic [15:0] dp, input logic [7:0] ifc);
    if (sender_idle && $urandom_range(3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(18, 1)) @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= cmd;
    source_port <= sp;
    dest_port <= dp;
    interface_id <= ifc;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(cmd, sp, dp, ifc);
  endtask

  task automatic send_random(input int add_weight);
    logic [1:0]  cmd;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  ifc;
    int r;
    int idx;
    sp = pick_port();
    dp = pick_port();
    ifc = pick_iface();
    r = $urandom_range(99);
    if (r < 3) cmd = CmdReserved;
    else if (r < 3 + add_weight * 97 / 100) cmd = pmt_pkg::CMD_ADD;
    else cmd = $urandom_range(1) ? pmt_pkg::CMD_REMOVE : pmt_pkg::CMD_LOOKUP;
    // mostly aim remove/lookup at a live entry
    if ((cmd == pmt_pkg::CMD_REMOVE || cmd == pmt_pkg::CMD_LOOKUP) &&
        $urandom_range(9) < 7) begin
      idx = tracker.random_index();
      if (idx >= 0) begin
        sp = tracker.src_q[idx];
        dp = tracker.dst_q[idx];
        ifc = tracker.ifc_q[idx];
      end
    end
    send_request(cmd, sp, dp, ifc);
  endtask

  initial begin
    for (cycle_count = 0; cycle_count < CycleLimit; cycle_count++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int add_weights[11] = '{60, 45, 92, 95, 90, 20, 8, 55, 96, 35, 50};
    tracker = new(TableDepth);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table, reserved command, extremes, duplicates, compaction
    send_request(pmt_pkg::CMD_LOOKUP, 16'h0000, 16'h0000, 8'h00);
    send_request(pmt_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 8'h00);
    send_request(CmdReserved, 16'h0000, 16'h0000, 8'h00);
    send_request(pmt_pkg::CMD_ADD, 16'h0000, 16'h0000, 8'h00);
    send_request(pmt_pkg::CMD_ADD, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(pmt_pkg::CMD_ADD, 16'h1234, 16'h0050, 8'h03);
    send_request(pmt_pkg::CMD_ADD, 16'h1234, 16'h0051, 8'h03);
    send_request(pmt_pkg::CMD_ADD, 16'h1234, 16'h0050, 8'h03);
    send_request(pmt_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 8'h03);
    send_request(pmt_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 8'h04);
    send_request(pmt_pkg::CMD_LOOKUP, 16'hFFFF, 16'h0000, 8'hFF);
    send_request(pmt_pkg::CMD_LOOKUP, 16'h0000, 16'hFFFF, 8'h00);
    send_request(pmt_pkg::CMD_REMOVE, 16'h1234, 16'h0050, 8'h00);
    send_request(pmt_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 8'h03);
    send_request(pmt_pkg::CMD_REMOVE, 16'h1234, 16'h9999, 8'h03);
    send_request(CmdReserved, 16'hFFFF, 16'hFFFF, 8'hFF);
    send_request(pmt_pkg::CMD_REMOVE, 16'h0000, 16'h0000, 8'hFF);
    send_request(pmt_pkg::CMD_REMOVE, 16'hFFFF, 16'hFFFF, 8'h00);
    send_request(pmt_pkg::CMD_LOOKUP, 16'h1234, 16'h0000, 8'h03);
    send_request(pmt_pkg::CMD_REMOVE, 16'h1234, 16'h0051, 8'h03);
    send_request(pmt_pkg::CMD_REMOVE, 16'h1234, 16'h0050, 8'h03);
    send_request(pmt_pkg::CMD_REMOVE, 16'h1234, 16'h0050, 8'h03);

    // phases: grow, fill past full, drain, refill; last phase without idling
    for (int p = 0; p < 11; p++) begin
      sender_idle = (p < 10) && ($urandom_range(3) != 0);
      receiver_idle = (p < 10) && ($urandom_range(3) != 0);
      if (p == 5) begin
        req_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        @(posedge clk);
      end
      repeat (100) send_random(add_weights[p]);
    end

    req_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * TableDepth + 8) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
